>>> design/look_ahead_iir_first_order_unit_defines.svh
// Assertion macros for the checker of the look-ahead IIR unit.
// No dependencies; include by bare file name.
`ifndef LOOK_AHEAD_IIR_FIRST_ORDER_UNIT_DEFINES_SVH
`define LOOK_AHEAD_IIR_FIRST_ORDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAHF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lahf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LAHF_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lahf assertion failed");

`endif

>>> design/lahf_pkg.sv
// Types, constants and saturating helpers for the look-ahead IIR unit.
// No dependencies.
`default_nettype none
package lahf_pkg;

  localparam int unsigned SampleW = 9;
  localparam int unsigned StateW  = 8;
  localparam int unsigned TdataW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [StateW-1:0] SatHi = 8'sd127;
  localparam logic signed [StateW-1:0] SatLo = -8'sd128;

  // Reset values after the one-bit pre-shift: a = -41, b0 = b1 = 107.
  localparam logic signed [StateW-1:0] AHalfRst = -8'sd21;
  localparam logic signed [StateW-1:0] A2Rst    = 8'sd0;
  localparam logic signed [StateW-1:0] BHalfRst = 8'sd53;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A  = 2'd0,
    REG_COEF_B0 = 2'd1,
    REG_COEF_B1 = 2'd2
  } reg_idx_e;

  // Coefficients as the datapath uses them.
  typedef struct packed {
    logic signed [StateW-1:0] a_half;
    logic signed [StateW-1:0] a_sq;
    logic signed [StateW-1:0] b0_half;
    logic signed [StateW-1:0] b1_half;
  } coef_t;

  function automatic logic signed [StateW-1:0] sat8(input logic signed [15:0] v);
    logic signed [StateW-1:0] r;
    if (v > 16'sd127) begin
      r = SatHi;
    end else if (v < -16'sd128) begin
      r = SatLo;
    end else begin
      r = v[StateW-1:0];
    end
    return r;
  endfunction

  // sat((p * q) >>> 7)
  function automatic logic signed [StateW-1:0] mul_q7(input logic signed [StateW-1:0] p,
                                                     input logic signed [StateW-1:0] q);
    logic signed [15:0] prod;
    prod = 16'(p) * 16'(q);
    return sat8(prod >>> 7);
  endfunction

  function automatic logic signed [StateW-1:0] add_sat(input logic signed [StateW-1:0] p,
                                                      input logic signed [StateW-1:0] q);
    logic signed [15:0] s;
    s = 16'(p) + 16'(q);
    return sat8(s);
  endfunction

  function automatic logic signed [StateW-1:0] sub_sat(input logic signed [StateW-1:0] p,
                                                      input logic signed [StateW-1:0] q);
    logic signed [15:0] s;
    s = 16'(p) - 16'(q);
    return sat8(s);
  endfunction

endpackage
`default_nettype wire

>>> design/lahf_cfg.sv
// Coefficient registers of the look-ahead IIR unit; squares a1 at write time.
// Depends on lahf_pkg.
`default_nettype none
module lahf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [lahf_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [lahf_pkg::SampleW-1:0]  wr_data_i,
  output lahf_pkg::coef_t                    coef_o
);
  import lahf_pkg::*;

  coef_t coef_q, coef_d;
  logic signed [StateW-1:0] wr_half;
  logic signed [15:0]       wr_sq;

  // arithmetic shift right by one of a 9-bit value
  assign wr_half = wr_data_i[SampleW-1:1];
  assign wr_sq   = 16'(wr_half) * 16'(wr_half);

  always_comb begin
    coef_d = coef_q;
    if (wr_en_i) begin
      unique case (reg_idx_e'(wr_idx_i))
        REG_COEF_A: begin
          coef_d.a_half = wr_half;
          coef_d.a_sq   = sat8(wr_sq >>> 9);
        end
        REG_COEF_B0: coef_d.b0_half = wr_half;
        REG_COEF_B1: coef_d.b1_half = wr_half;
        default: coef_d = coef_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a_half  <= AHalfRst;
      coef_q.a_sq    <= A2Rst;
      coef_q.b0_half <= BHalfRst;
      coef_q.b1_half <= BHalfRst;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

>>> design/lahf_core.sv
// Filter state and one-step look-ahead recursion of the IIR unit.
// Depends on lahf_pkg.
`default_nettype none
module lahf_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [lahf_pkg::SampleW-1:0] sample_i,
  input  wire lahf_pkg::coef_t              coef_i,
  output logic [lahf_pkg::SampleW-1:0]      result_o
);
  import lahf_pkg::*;

  logic signed [StateW-1:0] feed_q, diff_q, delay_q, prod_q, sum_q, out_dly_q;
  logic signed [StateW-1:0] feed_d, diff_d, prod_d, sum_d;
  logic signed [StateW-1:0] xs, t0, t1, y;

  assign xs = sample_i[SampleW-1:1];

  assign t0 = mul_q7(coef_i.b0_half, sum_q);
  assign t1 = mul_q7(coef_i.b1_half, out_dly_q);
  assign y  = add_sat(t0, t1);

  assign sum_d  = add_sat(diff_q, prod_q);
  assign prod_d = mul_q7(coef_i.a_sq, delay_q);
  assign diff_d = sub_sat(xs, feed_q);
  assign feed_d = mul_q7(coef_i.a_half, xs);

  // output is the saturated value doubled
  assign result_o = {y, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q    <= '0;
      diff_q    <= '0;
      delay_q   <= '0;
      prod_q    <= '0;
      sum_q     <= '0;
      out_dly_q <= '0;
    end else if (step_i) begin
      out_dly_q <= delay_q;
      sum_q     <= sum_d;
      prod_q    <= prod_d;
      delay_q   <= sum_d;
      diff_q    <= diff_d;
      feed_q    <= feed_d;
    end
  end

endmodule
`default_nettype wire

>>> design/lahf_obuf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on lahf_pkg.
`default_nettype none
module lahf_obuf (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lahf_pkg::SampleW-1:0] in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lahf_pkg::SampleW-1:0]      out_data_o
);
  import lahf_pkg::*;

  logic               out_valid_q, skid_valid_q;
  logic [SampleW-1:0] out_data_q, skid_data_q;
  logic               push, take;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign take       = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

>>> design/look_ahead_iir_first_order_unit.sv
// Look-ahead first-order IIR unit: 9-bit samples in, 9-bit filtered samples out.
// The result is registered into the output buffer (result or skid register) as the item is accepted.
// Throughput: one item per cycle while the skid register is free; each recursion step is a saturating multiply-add.
// Output is buffered two deep, so input keeps flowing during an output stall until the skid register fills.
// Reset (async, active low) clears all filter state and output valid and loads
// the default coefficients a1 = -41, b0 = b1 = 107.
`default_nettype none
module look_ahead_iir_first_order_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // sample input stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [lahf_pkg::TdataW-1:0]  s_axis_tdata_i,  // [8:0] sample_in, [15:9] zero
  // filtered output stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [lahf_pkg::TdataW-1:0]       m_axis_tdata_o,  // [8:0] sample_out, [15:9] zero
  // coefficient write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lahf_pkg::CfgIdxW-1:0] cfg_index_i,     // 0: a1, 1: b0, 2: b1
  input  wire logic [lahf_pkg::SampleW-1:0] cfg_data_i
);
  import lahf_pkg::*;

  coef_t              coef;
  logic               in_ready;
  logic               accept;
  logic [SampleW-1:0] result;
  logic [SampleW-1:0] out_data;

  // coefficient writes are always accepted and take effect in the next cycle
  assign cfg_ready_o = 1'b1;

  lahf_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .coef_o    (coef)
  );

  // state advances only on an accepted item
  assign accept = s_axis_tvalid_i && in_ready;

  lahf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .sample_i (s_axis_tdata_i[SampleW-1:0]),
    .coef_i   (coef),
    .result_o (result)
  );

  // ready depends only on the skid slot being free
  lahf_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = {{(TdataW-SampleW){1'b0}}, out_data};

endmodule
`default_nettype wire

>>> design/lahf_checker.sv
// Port-level checker for the look-ahead IIR unit, bound to the top level.
// Depends on lahf_pkg and the defines header.
`default_nettype none
`include "look_ahead_iir_first_order_unit_defines.svh"
module lahf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [lahf_pkg::TdataW-1:0]  m_axis_tdata_o
);
  import lahf_pkg::*;

  logic out_stall;
  logic in_take;
  logic out_fmt_ok;

  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_take    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fmt_ok = m_axis_tdata_o[0] == 1'b0 && m_axis_tdata_o[TdataW-1:SampleW] == '0;

  `LAHF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o)
  `LAHF_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o))
  `LAHF_ASSERT_NOW(a_out_even, clk_i, rst_ni, m_axis_tvalid_o, out_fmt_ok)
  `LAHF_ASSERT_NXT(a_in_to_out, clk_i, rst_ni, in_take, m_axis_tvalid_o)

endmodule

bind look_ahead_iir_first_order_unit lahf_checker u_lahf_checker (.*);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for look_ahead_iir_first_order_unit.
// Predicts each filtered sample from the coefficient registers and the filter state.
// Depends on lahf_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
  import lahf_pkg::*;

  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] RegIdxUnused = 2'd3;
  localparam int MaxGap        = 18;
  localparam int CycleLimit    = 300000;
  localparam int MaxReported   = 10;
  localparam int RandomPhases  = 4;
  localparam int ItemsPerPhase = 80;

  logic clk_i;
  logic rst_ni;

  logic                 s_axis_tvalid;
  logic                 s_axis_tready_o;
  logic [TdataW-1:0]    s_axis_tdata;     // [8:0] sample_in, [15:9] pad
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready;
  logic [TdataW-1:0]    m_axis_tdata_o;   // [8:0] sample_out, [15:9] pad
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [SampleW-1:0]   cfg_data;

  look_ahead_iir_first_order_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Shadow coefficient registers, as written over the config channel.
  logic signed [SampleW-1:0] shadow_a;
  logic signed [SampleW-1:0] shadow_b0;
  logic signed [SampleW-1:0] shadow_b1;

  // Shadow filter state, all signed 8-bit.
  logic signed [StateW-1:0] feed_r;
  logic signed [StateW-1:0] diff_r;
  logic signed [StateW-1:0] delay_r;
  logic signed [StateW-1:0] prod_r;
  logic signed [StateW-1:0] sum_r;
  logic signed [StateW-1:0] out_dly_r;

  // Filtered samples still owed by the unit, oldest first.
  logic [SampleW-1:0] filtered_q[$];

  int  mismatches;
  int  cycles;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  int  rx_hold_cycles;   // long output stall requested by a test

  always #5 clk_i = ~clk_i;

  // Clamp to the 8-bit signed range.
  function automatic logic signed [StateW-1:0] clamp8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return 8'(v);
  endfunction

  // Advance the shadow filter by one sample and return the expected output.
  // Every right-hand side reads the state as it was before this sample.
  function automatic logic [SampleW-1:0] iir_next_output(input logic signed [SampleW-1:0] x);
    int xs, ah, a_sq, t0, t1, y;
    logic signed [StateW-1:0] nsum, nprod, ndiff, nfeed;
    xs    = int'(x) >>> 1;
    ah    = int'(shadow_a) >>> 1;
    a_sq  = clamp8((ah * ah) >>> 9);
    t0    = clamp8(((int'(shadow_b0) >>> 1) * int'(sum_r)) >>> 7);
    t1    = clamp8(((int'(shadow_b1) >>> 1) * int'(out_dly_r)) >>> 7);
    y     = clamp8(t0 + t1);
    nsum  = clamp8(int'(diff_r) + int'(prod_r));
    nprod = clamp8((a_sq * int'(delay_r)) >>> 7);
    ndiff = clamp8(xs - int'(feed_r));
    nfeed = clamp8((ah * xs) >>> 7);
    out_dly_r = delay_r;
    sum_r     = nsum;
    prod_r    = nprod;
    delay_r   = nsum;
    diff_r    = ndiff;
    feed_r    = nfeed;
    return {y[StateW-1:0], 1'b0};
  endfunction

  // Offer one sample, after a random gap if tx gaps are on; returns at the edge it is taken.
  // Valid stays high on return so that a back-to-back item needs no toggle.
  task automatic push_sample(input logic signed [SampleW-1:0] x,
                             input logic [TdataW-SampleW-1:0] pad = '0);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pad, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    filtered_q.push_back(iir_next_output(x));
  endtask

  // Stop offering and wait for every owed sample, plus the unit's latency.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Coefficient write; only called with the unit idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic signed [SampleW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COEF_A:  shadow_a  = val;
      REG_COEF_B0: shadow_b0 = val;
      REG_COEF_B1: shadow_b1 = val;
      default: ;  // unmapped index, dropped
    endcase
  endtask

  task automatic write_coefs(input logic signed [SampleW-1:0] a,
                             input logic signed [SampleW-1:0] b0,
                             input logic signed [SampleW-1:0] b1);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
  endtask

  // Coefficient draw biased toward the ends of the range.
  function automatic logic signed [SampleW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return -9'sd256;
      1:       return 9'sd255;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return -9'sd256;
      1:       return 9'sd255;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // Reset coefficients, full-scale steps, sign edges, and junk in the pad bits.
  task automatic test_reset_coefs();
    push_sample(9'sd0);
    push_sample(9'sd255);
    push_sample(9'sd255, '1);
    push_sample(-9'sd256);
    push_sample(-9'sd256, 7'h55);
    push_sample(9'sd1);
    push_sample(-9'sd1);
    push_sample(9'sd0);
    drain_results();
  endtask

  // Both extremes of every coefficient, driving the loop into saturation.
  task automatic test_coef_extremes();
    write_coefs(-9'sd256, -9'sd256, 9'sd255);
    push_sample(9'sd255);
    push_sample(9'sd255);
    push_sample(-9'sd256);
    push_sample(-9'sd256);
    push_sample(9'sd255);
    push_sample(9'sd0);
    drain_results();
    write_coefs(9'sd255, 9'sd255, -9'sd256);
    push_sample(-9'sd256);
    push_sample(-9'sd256);
    push_sample(9'sd255);
    push_sample(9'sd255);
    push_sample(-9'sd1);
    drain_results();
  endtask

  // A write to the unmapped index must leave the filter untouched.
  task automatic test_unmapped_index();
    write_reg(RegIdxUnused, 9'sd0);
    push_sample(9'sd200);
    push_sample(-9'sd200);
    push_sample(9'sd77);
    drain_results();
  endtask

  // Random coefficient sets, random samples, idling switched in stretches.
  task automatic test_random_phases();
    for (int p = 0; p < RandomPhases; p++) begin
      write_coefs(pick_coef(), pick_coef(), pick_coef());
      if ($urandom_range(0, 1)) write_reg(RegIdxUnused, 9'($urandom_range(0, 511)));
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 20 == 0) begin
          tx_gaps_on = $urandom_range(0, 3) != 0;
          rx_gaps_on = $urandom_range(0, 3) != 0;
        end
        push_sample(pick_sample(), ($urandom_range(0, 7) == 0) ? 7'($urandom) : '0);
      end
      drain_results();
    end
  endtask

  // Output held off for a long stretch while input streams back to back,
  // so the output buffer fills and the input stalls.
  task automatic test_output_stall();
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = 120;
    for (int i = 0; i < 40; i++) push_sample(pick_sample());
    drain_results();
  endtask

  // Sender stops until everything owed has come, then resumes on the same state.
  task automatic test_sender_pause();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    for (int i = 0; i < 10; i++) push_sample(pick_sample());
    drain_results();
    for (int i = 0; i < 10; i++) push_sample(pick_sample());
    drain_results();
  endtask

  // Receiver: random stall before each item, plus any long hold a test asks for.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_hold_cycles + (rx_gaps_on ? $urandom_range(0, MaxGap) : 0);
      rx_hold_cycles = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Result checker: compare each taken output with the oldest prediction.
  always @(posedge clk_i) begin
    logic [SampleW-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected output item: sample_out=%0d",
                   $signed(m_axis_tdata_o[SampleW-1:0]));
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata_o[SampleW-1:0] !== want) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("sample_out mismatch: expected %0d, got %0d",
                     $signed(want), $signed(m_axis_tdata_o[SampleW-1:0]));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL look_ahead_iir_first_order_unit");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatches     = 0;
    cycles         = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    rx_hold_cycles = 0;
    // Shadow model after reset: default coefficients, cleared state.
    shadow_a  = -9'sd41;
    shadow_b0 = 9'sd107;
    shadow_b1 = 9'sd107;
    feed_r    = '0;
    diff_r    = '0;
    delay_r   = '0;
    prod_r    = '0;
    sum_r     = '0;
    out_dly_r = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_coefs();
    test_coef_extremes();
    test_unmapped_index();
    test_random_phases();
    test_output_stall();
    test_sender_pause();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS look_ahead_iir_first_order_unit");
    end else begin
      $display("FAIL look_ahead_iir_first_order_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lahf_pkg.sv
design/lahf_cfg.sv
design/lahf_core.sv
design/lahf_obuf.sv
design/look_ahead_iir_first_order_unit.sv
design/lahf_checker.sv
dv/tb.sv
